FILE: rtl/error_derivative_moving_average_macros.svh
// assertion macros for the error derivative moving average block
// used by the port checker, expects clk and rst in scope
`ifndef ERROR_DERIVATIVE_MOVING_AVERAGE_MACROS_SVH
`define ERROR_DERIVATIVE_MOVING_AVERAGE_MACROS_SVH

// same-cycle implication, disabled in reset
`define EDMA_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("edma check failed");

// next-cycle implication, disabled in reset
`define EDMA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("edma check failed");

`endif

FILE: rtl/edma_pkg.sv
// shared constants and types for the error derivative moving average block
// no dependencies
`timescale 1ns / 1ps

package edma_pkg;

  localparam int DEFAULT_WINDOW = 100;
  localparam int DATA_W = 32;
  localparam int DIV_N = 52;
  localparam logic [19:0] USEC_PER_SEC = 20'd1000000;
  localparam int NUM_AVG = 4;
  localparam int NUM_RES = 6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_START,
    ST_DIV,
    ST_UPD,
    ST_OUT
  } edma_state_t;

endpackage

FILE: rtl/error_derivative_moving_average.sv
// error derivative moving average, top level
// depends on edma_pkg, edma_ram, edma_div
//
// input channel: pos_x, pos_y (signed Q16.16) and time_us, taken on
// in_valid && !in_stall. output channel: eight unsigned Q16.16 fields,
// taken on out_valid && !out_stall.
// the first sample only records errors and time; a sample with the same
// timestamp as the previous one only rewrites the time. neither gives a
// result and both finish in the accepting cycle.
// any other sample runs six divisions through one shared bit-serial
// divider (two rates, four means) and a window update through the
// sample memory before its result is shown.
// one request is in flight at a time; in_stall stays high until the
// result has been taken, so a stalled receiver holds the block and no
// new request is taken before the last result has left.
// the window store needs no clearing pass: an old slot value is not
// subtracted until the window is full, so the block is ready the cycle after reset.
// reset clears the timing history, fill count, window sums and control.
`timescale 1ns / 1ps

module error_derivative_moving_average #(
  parameter int WINDOW = edma_pkg::DEFAULT_WINDOW
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic [31:0] time_us,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] abs_err_x,
  output logic [31:0] abs_err_y,
  output logic [31:0] rate_x,
  output logic [31:0] rate_y,
  output logic [31:0] mean_err_x,
  output logic [31:0] mean_err_y,
  output logic [31:0] mean_rate_x,
  output logic [31:0] mean_rate_y
);

  import edma_pkg::*;

  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int FILL_W = $clog2(WINDOW + 1);
  localparam int SUM_W  = DATA_W + FILL_W;
  localparam int MEM_W  = DATA_W * NUM_AVG;

  edma_state_t state, state_next;

  logic              have_time;
  logic [31:0]       last_time;
  logic [31:0]       last_x, last_y;
  logic [SLOT_W-1:0] slot;
  logic [FILL_W-1:0] fill;
  logic              was_full;
  logic [SUM_W-1:0]  sums [NUM_AVG];
  logic [31:0]       ax, ay, dx, dy, delta;
  logic [31:0]       res [NUM_RES];
  logic [2:0]        k;
  logic [DIV_N-1:0]  div_a;
  logic [31:0]       div_b;
  logic              div_start, div_done;
  logic [DIV_N-1:0]  div_q;
  logic [31:0]       div_sat;
  logic [MEM_W-1:0]  rd_data, wr_data;
  logic              mem_we;

  logic [31:0] in_ax, in_ay, in_delta;

  function automatic logic [31:0] mag(input logic [31:0] v);
    return v[31] ? (32'd0 - v) : v;
  endfunction

  function automatic logic [31:0] adiff(input logic [31:0] a, input logic [31:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  assign in_ax    = mag(pos_x);
  assign in_ay    = mag(pos_y);
  assign in_delta = time_us - last_time;
  assign in_stall = (state != ST_IDLE);
  assign div_sat  = (|div_q[DIV_N-1:32]) ? 32'hFFFF_FFFF : div_q[31:0];
  assign mem_we   = (state == ST_UPD);
  assign wr_data  = {res[1], res[0], ay, ax};

  edma_ram #(.WIDTH(MEM_W), .DEPTH(WINDOW)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (slot),
    .wdata (wr_data),
    .raddr (slot),
    .rdata (rd_data)
  );

  edma_div #(.N(DIV_N), .D(DATA_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && have_time && in_delta != 32'd0) begin
          state_next = ST_PREP;
        end
      end
      ST_PREP:  state_next = ST_START;
      ST_START: begin
        div_start  = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          if (k == 3'd1) begin
            state_next = ST_UPD;
          end else if (k == 3'(NUM_RES - 1)) begin
            state_next = ST_OUT;
          end else begin
            state_next = ST_PREP;
          end
        end
      end
      ST_UPD:   state_next = ST_PREP;
      ST_OUT: begin
        if (!out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_time <= 1'b0;
      last_time <= '0;
      last_x    <= '0;
      last_y    <= '0;
      slot      <= '0;
      fill      <= '0;
      out_valid <= 1'b0;
      k         <= '0;
      for (int i = 0; i < NUM_AVG; i++) begin
        sums[i] <= '0;
      end
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            last_time <= time_us;
            if (!have_time) begin
              have_time <= 1'b1;
              last_x    <= in_ax;
              last_y    <= in_ay;
            end else if (in_delta != 32'd0) begin
              last_x   <= in_ax;
              last_y   <= in_ay;
              ax       <= in_ax;
              ay       <= in_ay;
              dx       <= adiff(in_ax, last_x);
              dy       <= adiff(in_ay, last_y);
              delta    <= in_delta;
              was_full <= (fill == FILL_W'(WINDOW));
              if (fill != FILL_W'(WINDOW)) begin
                fill <= fill + 1'b1;
              end
              k <= '0;
            end
          end
        end
        ST_PREP: begin
          if (k == 3'd0) begin
            div_a <= {20'd0, dx} * {32'd0, USEC_PER_SEC};
            div_b <= delta;
          end else if (k == 3'd1) begin
            div_a <= {20'd0, dy} * {32'd0, USEC_PER_SEC};
            div_b <= delta;
          end else begin
            div_a <= DIV_N'(sums[k[1:0] - 2'd2]);
            div_b <= 32'(fill);
          end
        end
        ST_DIV: begin
          if (div_done) begin
            res[k] <= div_sat;
            if (k == 3'(NUM_RES - 1)) begin
              out_valid <= 1'b1;
            end else if (k != 3'd1) begin
              k <= k + 1'b1;
            end
          end
        end
        ST_UPD: begin
          for (int i = 0; i < NUM_AVG; i++) begin
            sums[i] <= sums[i]
                       - (was_full ? SUM_W'(rd_data[i*DATA_W +: DATA_W]) : SUM_W'(0))
                       + SUM_W'(wr_data[i*DATA_W +: DATA_W]);
          end
          slot <= (slot == SLOT_W'(WINDOW - 1)) ? '0 : slot + 1'b1;
          k    <= 3'd2;
        end
        ST_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  assign abs_err_x   = ax;
  assign abs_err_y   = ay;
  assign rate_x      = res[0];
  assign rate_y      = res[1];
  assign mean_err_x  = res[2];
  assign mean_err_y  = res[3];
  assign mean_rate_x = res[4];
  assign mean_rate_y = res[5];

endmodule

FILE: rtl/edma_ram.sv
// generic single-port-write, registered-read memory
// no dependencies
`timescale 1ns / 1ps

module edma_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/edma_div.sv
// iterative restoring divider, one quotient bit per cycle
// depends on edma_pkg
`timescale 1ns / 1ps

module edma_div #(
  parameter int N = edma_pkg::DIV_N,
  parameter int D = edma_pkg::DATA_W
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [N-1:0] dividend,
  input  logic [D-1:0] divisor,
  output logic         done,
  output logic [N-1:0] quotient
);

  localparam int CNT_W = $clog2(N + 1);

  logic [D:0]       rem;
  logic [D-1:0]     den;
  logic [CNT_W-1:0] cnt;
  logic             run;
  logic [D:0]       rem_sh;
  logic             ge;

  assign rem_sh = {rem[D-1:0], quotient[N-1]};
  assign ge     = rem_sh >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run      <= 1'b1;
        cnt      <= CNT_W'(N);
        rem      <= '0;
        den      <= divisor;
        quotient <= dividend;
      end else if (run) begin
        rem      <= ge ? (rem_sh - {1'b0, den}) : rem_sh;
        quotient <= {quotient[N-2:0], ge};
        cnt      <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: rtl/edma_check.sv
// port-level checker for the error derivative moving average block
// depends on error_derivative_moving_average_macros.svh, bound to the top level
`timescale 1ns / 1ps
`include "error_derivative_moving_average_macros.svh"

module edma_check (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] abs_err_x,
  input logic [31:0] mean_err_x,
  input logic [31:0] mean_err_y
);

  // a held result keeps its value
  `EDMA_ASSERT_NEXT(held_result, out_valid && out_stall, out_valid && $stable(mean_err_x))
  // no new request while a result waits
  `EDMA_ASSERT(busy_with_result, out_valid, in_stall)
  // magnitudes never exceed two to the thirty-first
  `EDMA_ASSERT(abs_range, out_valid, abs_err_x <= 32'h8000_0000)
  `EDMA_ASSERT(mean_range, out_valid,
               mean_err_x <= 32'h8000_0000 && mean_err_y <= 32'h8000_0000)

endmodule

bind error_derivative_moving_average edma_check u_edma_check (
  .clk        (clk),
  .rst        (rst),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .abs_err_x  (abs_err_x),
  .mean_err_x (mean_err_x),
  .mean_err_y (mean_err_y)
);

FILE: bench/edma_checker.sv
// checker for the error derivative moving average block: predicts each result
// from the accepted requests and compares it with the output channel
// depends on edma_pkg
`timescale 1ns / 1ps

module edma_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic [31:0] time_us,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] abs_err_x,
  input  logic [31:0] abs_err_y,
  input  logic [31:0] rate_x,
  input  logic [31:0] rate_y,
  input  logic [31:0] mean_err_x,
  input  logic [31:0] mean_err_y,
  input  logic [31:0] mean_rate_x,
  input  logic [31:0] mean_rate_y,
  output int          pending,
  output int          fails
);
  import edma_pkg::*;

  localparam int WIN = DEFAULT_WINDOW;

  typedef struct {
    logic [31:0] ax, ay, rx, ry, mex, mey, mrx, mry;
  } err_stats_t;

  err_stats_t stats_q[$];

  logic        seen_first;
  logic [31:0] last_t, last_ax, last_ay;
  int          slot, filled;
  logic [31:0] window_vals[NUM_AVG][WIN];
  logic [63:0] window_sum[NUM_AVG];

  assign pending = stats_q.size();

  function automatic logic [31:0] abs32(logic [31:0] v);
    return v[31] ? (32'd0 - v) : v;
  endfunction

  function automatic logic [31:0] err_rate(logic [31:0] cur, logic [31:0] old,
                                           logic [31:0] dt);
    logic [63:0] d, q;
    d = (cur >= old) ? 64'(cur - old) : 64'(old - cur);
    q = (d * 64'd1000000) / 64'(dt);
    return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
  endfunction

  function automatic logic [31:0] window_mean(int k, logic [31:0] v);
    window_sum[k] = window_sum[k] - 64'(window_vals[k][slot]) + 64'(v);
    window_vals[k][slot] = v;
    return 32'(window_sum[k] / 64'(filled));
  endfunction

  task automatic track_sample(logic [31:0] px, logic [31:0] py, logic [31:0] t);
    logic [31:0] dt;
    err_stats_t e;
    e.ax = abs32(px);
    e.ay = abs32(py);
    if (!seen_first) begin
      seen_first = 1'b1;
      last_t = t;
      last_ax = e.ax;
      last_ay = e.ay;
      return;
    end
    dt = t - last_t;
    last_t = t;
    if (dt == 32'd0) return;
    e.rx = err_rate(e.ax, last_ax, dt);
    e.ry = err_rate(e.ay, last_ay, dt);
    last_ax = e.ax;
    last_ay = e.ay;
    if (filled < WIN) filled++;
    e.mex = window_mean(0, e.ax);
    e.mey = window_mean(1, e.ay);
    e.mrx = window_mean(2, e.rx);
    e.mry = window_mean(3, e.ry);
    slot = (slot + 1 >= WIN) ? 0 : slot + 1;
    stats_q.push_back(e);
  endtask

  task automatic cmp(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      fails++;
    end
  endtask

  initial fails = 0;

  always @(posedge clk) begin
    err_stats_t e;
    if (rst) begin
      seen_first = 1'b0;
      last_t = '0;
      last_ax = '0;
      last_ay = '0;
      slot = 0;
      filled = 0;
      for (int k = 0; k < NUM_AVG; k++) begin
        window_sum[k] = '0;
        for (int i = 0; i < WIN; i++) window_vals[k][i] = '0;
      end
      stats_q.delete();
    end else begin
      if (in_valid && !in_stall) track_sample(pos_x, pos_y, time_us);
      if (out_valid && !out_stall) begin
        if (stats_q.size() == 0) begin
          $error("result with no request pending");
          fails++;
        end else begin
          e = stats_q.pop_front();
          cmp("abs_err_x", e.ax, abs_err_x);
          cmp("abs_err_y", e.ay, abs_err_y);
          cmp("rate_x", e.rx, rate_x);
          cmp("rate_y", e.ry, rate_y);
          cmp("mean_err_x", e.mex, mean_err_x);
          cmp("mean_err_y", e.mey, mean_err_y);
          cmp("mean_rate_x", e.mrx, mean_rate_x);
          cmp("mean_rate_y", e.mry, mean_rate_y);
        end
      end
    end
  end

endmodule

FILE: bench/tb.sv
// testbench top for the error derivative moving average block: directed and
// random position/time requests with random idling on both channels
// depends on edma_pkg, edma_checker and the block
`timescale 1ns / 1ps

module tb;
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic signed [31:0] pos_x = '0;
  logic signed [31:0] pos_y = '0;
  logic [31:0] time_us = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] abs_err_x, abs_err_y, rate_x, rate_y;
  logic [31:0] mean_err_x, mean_err_y, mean_rate_x, mean_rate_y;
  int          pending, fails;
  logic        hold_long = 1'b0;
  logic        busy_mode = 1'b1;
  logic [31:0] now_us = 32'd1000;

  always #4 clk = ~clk;

  error_derivative_moving_average dut (.*);

  edma_checker chk (.*);

  function automatic int draw_gap();
    if (!busy_mode) return 0;
    return ($urandom_range(0, 3) == 0) ? $urandom_range(4, 17) : $urandom_range(0, 3);
  endfunction

  function automatic logic [31:0] draw_pos();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'h8000_0000;
      2: return 32'h7FFF_FFFF;
      default: return 32'(int'($urandom_range(0, 32'h0040_0000)) - 32'h0020_0000);
    endcase
  endfunction

  function automatic logic [31:0] draw_step();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return $urandom();
      2: return $urandom_range(1, 3);
      3: return $urandom_range(1, 2_000_000);
      default: return $urandom_range(10_000, 100_000);
    endcase
  endfunction

  task automatic send(logic [31:0] px, logic [31:0] py, logic [31:0] t);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    pos_x <= px;
    pos_y <= py;
    time_us <= t;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_next(logic [31:0] px, logic [31:0] py, logic [31:0] dt);
    now_us = now_us + dt;
    send(px, py, now_us);
  endtask

  // receiver side
  initial begin
    int n;
    @(negedge rst);
    forever begin
      n = hold_long ? 3000 : draw_gap();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    int guard;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // first sample, then same timestamp, then extremes
    send_next(32'h8000_0000, 32'h7FFF_FFFF, 0);
    send_next(32'h0001_0000, 32'h0, 0);
    send_next(32'h7FFF_FFFF, 32'h8000_0000, 1);
    send_next(32'h8000_0000, 32'h0, 1);
    send_next(32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_next(32'hFFFF_0000, 32'h0001_0000, 50_000);
    // timestamp wrap
    now_us = 32'hFFFF_FF00;
    send_next(32'h0002_0000, 32'h0003_0000, 0);
    send_next(32'h0002_8000, 32'hFFFD_0000, 32'h200);
    send_next(32'h0, 32'h0, 32'hFFFF_FFFF);
    send_next(32'h8000_0000, 32'h8000_0000, 7);
    send_next(32'h8000_0000, 32'h8000_0000, 0);
    send_next(32'h1234_5678, 32'hEDCB_A988, 100_000);

    for (int i = 0; i < 440; i++) begin
      if (i % 60 == 0) busy_mode <= ~busy_mode;
      if (i == 150) hold_long <= 1'b1;
      if (i == 154) hold_long <= 1'b0;
      if (i == 300) begin
        wait (pending == 0);
        @(posedge clk);
      end
      send_next(draw_pos(), draw_pos(), draw_step());
    end
    in_valid <= 1'b0;

    guard = 0;
    while (pending != 0 && guard < 100_000) begin
      @(posedge clk);
      guard++;
    end
    repeat (400) @(posedge clk);
    if (fails == 0 && pending == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb failed");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/edma_pkg.sv
rtl/edma_ram.sv
rtl/edma_div.sv
rtl/error_derivative_moving_average.sv
rtl/edma_check.sv
bench/edma_checker.sv
bench/tb.sv
